[src/tip_pkg.sv]
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types, codes and constants of the text integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tip_pkg;

	typedef enum logic [2:0] {
		PH_WS       = 3'd0,
		PH_PREFIX   = 3'd1,
		PH_PREFIX_X = 3'd2,
		PH_DIGITS   = 3'd3
	} phase_t;

	typedef enum logic [2:0] {
		A_END   = 3'd0,
		A_SKIP  = 3'd1,
		A_SIGN  = 3'd2,
		A_ZERO  = 3'd3,
		A_HEX   = 3'd4,
		A_DIGIT = 3'd5,
		A_STOP  = 3'd6,
		A_SAT   = 3'd7
	} act_t;

	typedef struct packed {
		logic       eot;
		logic       space;
		logic       plus;
		logic       minus;
		logic       zero;
		logic       low_x;
		logic       dig_ok;
		logic [5:0] dig;
	} cmd_t;

	typedef struct packed {
		logic [5:0] base_select;
		logic       signed_mode;
		logic [1:0] size_select;
		logic [7:0] width_limit;
	} cfg_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic        saturated;
		logic        char_taken;
	} res_t;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_SIGNED = 2'd1;
	localparam logic [1:0] REG_SIZE   = 2'd2;
	localparam logic [1:0] REG_WIDTH  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NODIG = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [5:0] BASE_RST   = 6'd10;
	localparam logic       SIGNED_RST = 1'b1;
	localparam logic [1:0] SIZE_RST   = 2'd2;
	localparam logic [7:0] WIDTH_RST  = 8'd0;

	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_HEX = 6'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	localparam logic [7:0] CR_MAX = 8'd255;

	function automatic logic [63:0] size_max(input logic sgn, input logic [1:0] size);
		logic [63:0] m;
		case (size)
			2'd0:    m = sgn ? 64'd127 : 64'd255;
			2'd1:    m = sgn ? 64'd32767 : 64'd65535;
			2'd2:    m = sgn ? 64'd2147483647 : 64'd4294967295;
			default: m = sgn ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[src/tip_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tip_cfg_regs
// APB register file: base, sign mode, size and width limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output tip_pkg::cfg_t          cfg
);

	tip_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_select <= tip_pkg::BASE_RST;
			cfg_q.signed_mode <= tip_pkg::SIGNED_RST;
			cfg_q.size_select <= tip_pkg::SIZE_RST;
			cfg_q.width_limit <= tip_pkg::WIDTH_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				tip_pkg::REG_BASE:   cfg_q.base_select <= pwdata[5:0];
				tip_pkg::REG_SIGNED: cfg_q.signed_mode <= pwdata[0];
				tip_pkg::REG_SIZE:   cfg_q.size_select <= pwdata[1:0];
				tip_pkg::REG_WIDTH:  cfg_q.width_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tip_pkg::REG_BASE:   prdata = {26'd0, cfg_q.base_select};
			tip_pkg::REG_SIGNED: prdata = {31'd0, cfg_q.signed_mode};
			tip_pkg::REG_SIZE:   prdata = {30'd0, cfg_q.size_select};
			tip_pkg::REG_WIDTH:  prdata = {24'd0, cfg_q.width_limit};
			default:             prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[src/tip_front.sv]
// ----------------------------------------------------------------------------
// tip_front
// Accepts characters, classifies them and queues the class words.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        char_code,
	input  wire logic              end_of_text,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              cmd_pop,
	output logic                   cmd_valid,
	output tip_pkg::cmd_t          cmd
);

	tip_pkg::cmd_t cls;
	tip_pkg::cmd_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		cls        = '0;
		cls.eot    = end_of_text;
		cls.space  = char_code inside {tip_pkg::CH_SPACE, [tip_pkg::CH_TAB:tip_pkg::CH_CR]};
		cls.plus   = (char_code == tip_pkg::CH_PLUS);
		cls.minus  = (char_code == tip_pkg::CH_MINUS);
		cls.zero   = (char_code == tip_pkg::CH_0);
		cls.low_x  = (char_code == tip_pkg::CH_LX);
		if (char_code inside {[tip_pkg::CH_0:tip_pkg::CH_9]}) begin
			cls.dig_ok = 1'b1;
			cls.dig    = 6'(char_code - tip_pkg::CH_0);
		end else if (char_code inside {[tip_pkg::CH_LA:tip_pkg::CH_LZ]}) begin
			cls.dig_ok = 1'b1;
			cls.dig    = 6'(char_code - tip_pkg::CH_LA) + 6'd10;
		end else if (char_code inside {[tip_pkg::CH_UA:tip_pkg::CH_UZ]}) begin
			cls.dig_ok = 1'b1;
			cls.dig    = 6'(char_code - tip_pkg::CH_UA) + 6'd10;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_push   = push & ~full;
	assign do_pop    = cmd_pop & cmd_valid;
	assign cmd       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

[src/tip_back.sv]
// ----------------------------------------------------------------------------
// tip_back
// Parse sequencer and accumulator; queues finished results.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tip_pkg::cfg_t     cfg,
	input  wire logic              cmd_valid,
	input  wire tip_pkg::cmd_t     cmd,
	output logic                   cmd_pop,
	input  wire logic              pop,
	output logic                   empty,
	output tip_pkg::res_t          res
);

	tip_pkg::phase_t phase_q, phase_d, ph_e;
	tip_pkg::act_t   act;
	logic [63:0]     acc_q, acc_d, acc_e;
	logic            neg_q, neg_d, neg_e;
	logic            ds_q, ds_d, ds_e;
	logic [5:0]      ab_q, ab_d, ab_e, b_e;
	logic [7:0]      cr_q, cr_d;
	logic            eof, lim_hit, done;
	logic [63:0]     lim;
	logic [69:0]     prod;
	logic [70:0]     sum;
	logic            ovf;
	logic            step, emit, take;
	logic [63:0]     val;
	tip_pkg::res_t   res_d;

	tip_pkg::res_t   res_mem_q [2];
	logic            res_wp_q;
	logic            res_rp_q;
	logic [1:0]      res_cnt_q;
	logic            res_full, res_push, res_pop;

	assign lim     = tip_pkg::size_max(cfg.signed_mode, cfg.size_select);
	assign lim_hit = (cfg.width_limit != 8'd0) && (cr_q >= cfg.width_limit);
	assign eof     = cmd.eot | lim_hit;

	assign res_full = (res_cnt_q == 2'd2);
	assign step     = cmd_valid & ~res_full;
	assign cmd_pop  = step;

	// path decode
	always_comb begin
		ph_e  = phase_q;
		ab_e  = ab_q;
		ds_e  = ds_q;
		neg_e = neg_q;
		acc_e = acc_q;
		act   = tip_pkg::A_STOP;
		done  = 1'b0;
		if (phase_q > tip_pkg::PH_DIGITS) begin
			ph_e  = tip_pkg::PH_WS;
			ab_e  = 6'd0;
			ds_e  = 1'b0;
			neg_e = 1'b0;
			acc_e = 64'd0;
		end
		if (ph_e == tip_pkg::PH_WS) begin
			if (eof) begin
				act  = tip_pkg::A_END;
				done = 1'b1;
			end else if (cmd.space) begin
				act  = tip_pkg::A_SKIP;
				done = 1'b1;
			end else begin
				ab_e  = cfg.base_select;
				neg_e = 1'b0;
				ds_e  = 1'b0;
				acc_e = 64'd0;
				ph_e  = (cfg.base_select == 6'd0) ? tip_pkg::PH_PREFIX : tip_pkg::PH_DIGITS;
				if (cfg.signed_mode && (cmd.plus || cmd.minus)) begin
					act  = tip_pkg::A_SIGN;
					done = 1'b1;
				end
			end
		end
		if (!done && ph_e == tip_pkg::PH_PREFIX) begin
			if (!eof && cmd.zero) begin
				act  = tip_pkg::A_ZERO;
				done = 1'b1;
			end else begin
				ab_e = tip_pkg::BASE_DEC;
				ph_e = tip_pkg::PH_DIGITS;
			end
		end else if (!done && ph_e == tip_pkg::PH_PREFIX_X) begin
			ph_e = tip_pkg::PH_DIGITS;
			if (!eof && cmd.low_x) begin
				act  = tip_pkg::A_HEX;
				done = 1'b1;
			end
		end
		b_e  = (ab_e == 6'd0) ? tip_pkg::BASE_DEC : ab_e;
		prod = 70'(acc_e) * 70'(b_e);
		sum  = {1'b0, prod} + 71'(cmd.dig);
		ovf  = sum > 71'(lim);
		if (!done) begin
			if (eof || !cmd.dig_ok || cmd.dig >= b_e) begin
				act = tip_pkg::A_STOP;
			end else if (ovf) begin
				act = tip_pkg::A_SAT;
			end else begin
				act = tip_pkg::A_DIGIT;
			end
		end
	end

	// next phase
	always_comb begin
		case (act)
			tip_pkg::A_SIGN:  phase_d = ph_e;
			tip_pkg::A_ZERO:  phase_d = tip_pkg::PH_PREFIX_X;
			tip_pkg::A_HEX:   phase_d = tip_pkg::PH_DIGITS;
			tip_pkg::A_DIGIT: phase_d = tip_pkg::PH_DIGITS;
			default:          phase_d = tip_pkg::PH_WS;
		endcase
	end

	// datapath and result
	always_comb begin
		emit  = (act == tip_pkg::A_END) || (act == tip_pkg::A_STOP) || (act == tip_pkg::A_SAT);
		take  = ~emit;
		ab_d  = ab_e;
		ds_d  = ds_e;
		neg_d = neg_e;
		acc_d = acc_e;
		case (act)
			tip_pkg::A_SIGN: neg_d = cmd.minus;
			tip_pkg::A_ZERO: begin
				ab_d = tip_pkg::BASE_OCT;
				ds_d = 1'b1;
			end
			tip_pkg::A_HEX:  ab_d = tip_pkg::BASE_HEX;
			tip_pkg::A_DIGIT: begin
				acc_d = sum[63:0];
				ds_d  = 1'b1;
			end
			default: ;
		endcase
		if (emit) begin
			ab_d  = 6'd0;
			ds_d  = 1'b0;
			neg_d = 1'b0;
			acc_d = 64'd0;
			cr_d  = 8'd0;
		end else begin
			cr_d = (cr_q == tip_pkg::CR_MAX) ? cr_q : cr_q + 8'd1;
		end

		if (act == tip_pkg::A_END) begin
			res_d.status = tip_pkg::ST_EMPTY;
		end else begin
			res_d.status = ds_e ? tip_pkg::ST_OK : tip_pkg::ST_NODIG;
		end
		val = (act == tip_pkg::A_SAT) ? lim : acc_e;
		if (res_d.status != tip_pkg::ST_OK) begin
			val = 64'd0;
		end
		if (neg_e) begin
			val = ~val + 64'd1;
		end
		res_d.value      = val;
		res_d.saturated  = (act == tip_pkg::A_SAT);
		res_d.char_taken = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tip_pkg::PH_WS;
			acc_q   <= 64'd0;
			neg_q   <= 1'b0;
			ds_q    <= 1'b0;
			ab_q    <= 6'd0;
			cr_q    <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			ds_q    <= ds_d;
			ab_q    <= ab_d;
			cr_q    <= cr_d;
		end
	end

	// result queue
	assign res_push = step & emit;
	assign empty    = (res_cnt_q == 2'd0);
	assign res_pop  = pop & ~empty;
	assign res      = res_mem_q[res_rp_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wp_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wp_q  <= 1'b0;
			res_rp_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wp_q <= ~res_wp_q;
			end
			if (res_pop) begin
				res_rp_q <= ~res_rp_q;
			end
			res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	a_res_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_ws_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tip_pkg::PH_WS |-> !neg_q && !ds_q && acc_q == 64'd0 && ab_q == 6'd0)
		else $error("parse state not clear while skipping whitespace");

	a_sat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_d.saturated |-> res_d.status == tip_pkg::ST_OK)
		else $error("saturated result without digits");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_d.status != tip_pkg::ST_OK |-> res_d.value == 64'd0)
		else $error("failed parse with nonzero value");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> phase_q == tip_pkg::PH_WS && cr_q == 8'd0)
		else $error("state not cleared after result");

endmodule

`default_nettype wire

[src/text_integer_parser_unit.sv]
// ----------------------------------------------------------------------------
// text_integer_parser_unit
// Streaming integer parser, one character word per cycle while neither queue is full.
// ----------------------------------------------------------------------------
// Characters are pushed one word per cycle and the block sustains one word
// per cycle while the result queue is not full: the front classifies each
// character into a two-entry command queue, the back applies it to the
// parse state (one 64x6 multiply-add by the base plus a compare against the
// size maximum), and a finished integer lands in a two-entry result queue.
// A result is written to the result queue when the back applies the
// character ending the parse from the command queue; it then shows on the
// result ports and can be popped. The ending character is never consumed
// (char_taken is 0) and has to be pushed again as the start of the next
// parse. No clearing pass is needed after reset.
`default_nettype none

module text_integer_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_text,
	input  wire logic        push,
	output logic             full,
	output logic [63:0]      value,
	output logic [1:0]       status,
	output logic             saturated,
	output logic             char_taken,
	output logic             empty,
	input  wire logic        pop,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	tip_pkg::cfg_t cfg;
	tip_pkg::cmd_t cmd;
	tip_pkg::res_t res;
	logic          cmd_valid;
	logic          cmd_pop;

	tip_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tip_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.push        (push),
		.full        (full),
		.cmd_pop     (cmd_pop),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	tip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign value      = res.value;
	assign status     = res.status;
	assign saturated  = res.saturated;
	assign char_taken = res.char_taken;

endmodule

`default_nettype wire
